[design/imh_pkg.sv]
// Package with the shared widths, codes and default sizes of the indexed min-heap.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
	localparam int unsigned CapacityDefault  = 1024;
	localparam int unsigned NodeCountDefault = 4096;
	localparam int unsigned ReqWidth    = 2;
	localparam int unsigned NodeWidth   = 12;
	localparam int unsigned KeyWidth    = 32;
	localparam int unsigned StatusWidth = 3;
	localparam int unsigned CountWidth  = 11;

	typedef enum logic [ReqWidth-1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_OK          = 3'd0,
		ST_PRESENT     = 3'd1,
		ST_NOT_PRESENT = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [KeyWidth-1:0] key;
		logic [NodeWidth-1:0]       node;
	} entry_t;
endpackage
`default_nettype wire

[design/indexed_min_heap_top.sv]
// Top level of the indexed binary min-heap with a node position map.
//
// A transaction is accepted at a rising edge with start high and busy low. It carries
// req_type (insert, pop minimum, update key, clear), node_id and key. The block then
// works alone under a sequencer that shares one read and one write port on the heap
// memory and on the position map, and keeps busy high until it answers. Each
// transaction gets exactly one answer: done is high for one cycle with popped_node,
// status and count, and the receiver must take it then; it cannot stall the block.
// The sift loop sets how long a transaction runs: each level going up passes through
// S_SU_READ and S_SU_CMP, and each level going down passes through S_SD_READ, S_SD_C1
// and S_SD_C2; a sift walks at most 10 levels with 1024 slots. Done rises in the same
// cycle that busy falls. A rejected request holds busy for one cycle, and a pop of an
// empty heap is answered straight from idle without raising busy.
// Clear sweeps the whole position map one entry a cycle, with busy high, and answers in
// the cycle after the sweep. After reset the same sweep runs with busy high and without
// an answer; the heap is then empty. Heap slots need no clearing since no slot beyond
// the entry count is ever used.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_top #(
	parameter int unsigned CAPACITY   = imh_pkg::CapacityDefault,
	parameter int unsigned NODE_COUNT = imh_pkg::NodeCountDefault
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [imh_pkg::ReqWidth-1:0]      req_type,
	input  wire logic [imh_pkg::NodeWidth-1:0]     node_id,
	input  wire logic signed [imh_pkg::KeyWidth-1:0] key,
	output logic                                   done,
	output logic [imh_pkg::NodeWidth-1:0]          popped_node,
	output logic [imh_pkg::StatusWidth-1:0]        status,
	output logic [imh_pkg::CountWidth-1:0]         count
);
	localparam int unsigned SW = $clog2(CAPACITY + 1);
	localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [SW-1:0] CapSlots = SW'(CAPACITY);
	localparam logic [NW-1:0] LastNode = NW'(NODE_COUNT - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOKUP, S_POP1, S_POP2, S_UPD_RD, S_UPD_PAR,
		S_SU_READ, S_SU_CMP, S_SD_READ, S_SD_C1, S_SD_C2, S_PLACE
	} state_t;

	state_t state_q;
	imh_pkg::req_t req_q;
	logic [imh_pkg::NodeWidth-1:0] node_q;
	logic signed [imh_pkg::KeyWidth-1:0] key_q;
	logic node_ok_q;
	logic [SW-1:0] count_q;
	logic [SW-1:0] slot_q;
	logic [NW-1:0] clr_addr_q;
	logic clr_answer_q;
	imh_pkg::entry_t child_q;
	logic right_ok_q;
	logic done_q;
	logic [imh_pkg::NodeWidth-1:0] popped_q;
	imh_pkg::status_t status_q;
	logic [SW-1:0] count_out_q;

	imh_pkg::entry_t heap_mem [0:CAPACITY];
	logic [SW-1:0] pmap_mem [0:NODE_COUNT-1];
	imh_pkg::entry_t heap_rd_q;
	logic [SW-1:0] pmap_rd_q;

	logic [SW-1:0] heap_raddr, heap_waddr;
	logic heap_we;
	imh_pkg::entry_t heap_wdata;
	logic [NW-1:0] pmap_raddr, pmap_waddr;
	logic pmap_we;
	logic [SW-1:0] pmap_wdata;

	logic [31:0] in_node_ext, q_node_ext, rd_node_ext, cnt_ext;
	logic in_node_ok;
	logic [SW:0] lchild, rchild, count_ext;
	logic [SW-1:0] parent;
	imh_pkg::entry_t best;
	logic [SW-1:0] best_idx;

	assign in_node_ext = 32'(node_id);
	assign q_node_ext  = 32'(node_q);
	assign rd_node_ext = 32'(heap_rd_q.node);
	assign in_node_ok  = in_node_ext < NODE_COUNT;
	assign lchild      = {slot_q, 1'b0};
	assign rchild      = {slot_q, 1'b1};
	assign count_ext   = {1'b0, count_q};
	assign parent      = slot_q >> 1;
	assign cnt_ext     = 32'(count_out_q);

	always_comb begin
		if (right_ok_q && (heap_rd_q.key < child_q.key)) begin
			best     = heap_rd_q;
			best_idx = rchild[SW-1:0];
		end else begin
			best     = child_q;
			best_idx = lchild[SW-1:0];
		end
	end

	always_comb begin
		heap_raddr = count_q;
		pmap_raddr = in_node_ext[NW-1:0];
		heap_we    = 1'b0;
		heap_waddr = slot_q;
		heap_wdata = heap_rd_q;
		pmap_we    = 1'b0;
		pmap_waddr = rd_node_ext[NW-1:0];
		pmap_wdata = slot_q;
		unique case (state_q)
			S_CLEAR: begin
				pmap_we    = 1'b1;
				pmap_waddr = clr_addr_q;
				pmap_wdata = '0;
			end
			S_IDLE: heap_raddr = SW'(1);
			S_LOOKUP: heap_raddr = pmap_rd_q;
			S_POP1: begin
				heap_raddr = count_q;
				pmap_we    = (rd_node_ext < NODE_COUNT);
				pmap_wdata = '0;
			end
			S_UPD_RD: heap_raddr = parent;
			S_SU_READ: heap_raddr = parent;
			S_UPD_PAR, S_SU_CMP: begin
				heap_we = (key_q < heap_rd_q.key);
				pmap_we = heap_we;
			end
			S_SD_READ: heap_raddr = lchild[SW-1:0];
			S_SD_C1: heap_raddr = rchild[SW-1:0];
			S_SD_C2: begin
				heap_we    = (best.key < key_q);
				heap_wdata = best;
				pmap_we    = heap_we;
				pmap_waddr = 32'(best.node) < NODE_COUNT ? NW'(32'(best.node)) : '0;
				pmap_we    = heap_we && (32'(best.node) < NODE_COUNT);
			end
			S_PLACE: begin
				heap_we    = 1'b1;
				heap_wdata = '{key: key_q, node: node_q};
				pmap_we    = node_ok_q;
				pmap_waddr = q_node_ext[NW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		heap_rd_q <= heap_mem[heap_raddr];
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		pmap_rd_q <= pmap_mem[pmap_raddr];
		if (pmap_we) begin
			pmap_mem[pmap_waddr] <= pmap_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			req_q     <= imh_pkg::req_t'(req_type);
			node_q    <= node_id;
			key_q     <= key;
			node_ok_q <= in_node_ok;
		end else if (state_q == S_POP2) begin
			node_q    <= heap_rd_q.node;
			key_q     <= heap_rd_q.key;
			node_ok_q <= rd_node_ext < NODE_COUNT;
		end
		if (state_q == S_SD_C1) begin
			child_q    <= heap_rd_q;
			right_ok_q <= rchild <= count_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			count_q      <= '0;
			slot_q       <= '0;
			clr_addr_q   <= '0;
			clr_answer_q <= 1'b0;
			done_q       <= 1'b0;
			popped_q     <= '0;
			status_q     <= imh_pkg::ST_OK;
			count_out_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + NW'(1);
					if (clr_addr_q == LastNode) begin
						clr_addr_q   <= '0;
						count_q      <= '0;
						state_q      <= S_IDLE;
						clr_answer_q <= 1'b0;
						if (clr_answer_q) begin
							done_q      <= 1'b1;
							popped_q    <= '0;
							status_q    <= imh_pkg::ST_OK;
							count_out_q <= '0;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						popped_q <= '0;
						status_q <= imh_pkg::ST_OK;
						unique case (imh_pkg::req_t'(req_type))
							imh_pkg::REQ_CLEAR: begin
								clr_answer_q <= 1'b1;
								state_q      <= S_CLEAR;
							end
							imh_pkg::REQ_POP: begin
								if (count_q == '0) begin
									done_q      <= 1'b1;
									status_q    <= imh_pkg::ST_EMPTY;
									count_out_q <= count_q;
								end else begin
									state_q <= S_POP1;
								end
							end
							default: state_q <= S_LOOKUP;
						endcase
					end
				end
				S_LOOKUP: begin
					count_out_q <= count_q;
					if (!node_ok_q) begin
						done_q   <= 1'b1;
						status_q <= imh_pkg::ST_NOT_PRESENT;
						state_q  <= S_IDLE;
					end else if (req_q == imh_pkg::REQ_INSERT) begin
						if (pmap_rd_q != '0) begin
							done_q   <= 1'b1;
							status_q <= imh_pkg::ST_PRESENT;
							state_q  <= S_IDLE;
						end else if (count_q >= CapSlots) begin
							done_q   <= 1'b1;
							status_q <= imh_pkg::ST_FULL;
							state_q  <= S_IDLE;
						end else begin
							count_q <= count_q + SW'(1);
							slot_q  <= count_q + SW'(1);
							state_q <= S_SU_READ;
						end
					end else if (pmap_rd_q == '0 || pmap_rd_q > count_q) begin
						done_q   <= 1'b1;
						status_q <= imh_pkg::ST_NOT_PRESENT;
						state_q  <= S_IDLE;
					end else begin
						slot_q  <= pmap_rd_q;
						state_q <= S_UPD_RD;
					end
				end
				S_POP1: begin
					popped_q <= heap_rd_q.node;
					state_q  <= S_POP2;
				end
				S_POP2: begin
					count_q <= count_q - SW'(1);
					slot_q  <= SW'(1);
					if (count_q == SW'(1)) begin
						done_q      <= 1'b1;
						count_out_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SD_READ;
					end
				end
				S_UPD_RD: begin
					if (heap_rd_q.key == key_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (slot_q > SW'(1)) begin
						state_q <= S_UPD_PAR;
					end else begin
						state_q <= S_SD_READ;
					end
				end
				S_UPD_PAR: begin
					if (key_q < heap_rd_q.key) begin
						slot_q  <= parent;
						state_q <= S_SU_READ;
					end else begin
						state_q <= S_SD_READ;
					end
				end
				S_SU_READ: begin
					state_q <= (slot_q > SW'(1)) ? S_SU_CMP : S_PLACE;
				end
				S_SU_CMP: begin
					if (key_q < heap_rd_q.key) begin
						slot_q  <= parent;
						state_q <= S_SU_READ;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_SD_READ: begin
					state_q <= (lchild <= count_ext) ? S_SD_C1 : S_PLACE;
				end
				S_SD_C1: state_q <= S_SD_C2;
				S_SD_C2: begin
					if (best.key < key_q) begin
						slot_q  <= best_idx;
						state_q <= S_SD_READ;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					done_q      <= 1'b1;
					count_out_q <= count_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign popped_node = popped_q;
	assign status      = status_q;
	assign count       = cnt_ext[imh_pkg::CountWidth-1:0];
endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the indexed min-heap: a scoreboard predicts every answer.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	localparam int unsigned Capacity = imh_pkg::CapacityDefault;
	localparam int unsigned NodeCount = imh_pkg::NodeCountDefault;
	localparam int unsigned IdleLimit = 30000;

	typedef logic [imh_pkg::NodeWidth-1:0] node_t;
	typedef logic signed [imh_pkg::KeyWidth-1:0] key_t;

	typedef struct {
		node_t popped;
		imh_pkg::status_t st;
		logic [imh_pkg::CountWidth-1:0] cnt;
	} answer_t;

	class heap_scoreboard;
		key_t slot_key[1:Capacity];
		node_t slot_node[1:Capacity];
		int unsigned where[NodeCount];
		int unsigned fill;
		answer_t pending[$];

		function new();
			foreach (where[i]) where[i] = 0;
			fill = 0;
		endfunction

		function void place(int unsigned s, key_t k, node_t n);
			slot_key[s] = k;
			slot_node[s] = n;
			where[n] = s;
		endfunction

		function void lift(int unsigned s, key_t k, node_t n);
			while (s > 1 && k < slot_key[s / 2]) begin
				place(s, slot_key[s / 2], slot_node[s / 2]);
				s = s / 2;
			end
			place(s, k, n);
		endfunction

		function void sink(int unsigned s, key_t k, node_t n);
			int unsigned c;
			while (2 * s <= fill) begin
				c = 2 * s;
				if (c != fill && slot_key[c + 1] < slot_key[c])
					c++;
				if (!(slot_key[c] < k))
					break;
				place(s, slot_key[c], slot_node[c]);
				s = c;
			end
			place(s, k, n);
		endfunction

		function void note(imh_pkg::req_t r, node_t n, key_t k);
			answer_t a;
			key_t lk;
			node_t ln;
			int unsigned p;
			a.popped = '0;
			a.st = imh_pkg::ST_OK;
			case (r)
				imh_pkg::REQ_INSERT: begin
					if (where[n] != 0)
						a.st = imh_pkg::ST_PRESENT;
					else if (fill >= Capacity)
						a.st = imh_pkg::ST_FULL;
					else begin
						fill++;
						lift(fill, k, n);
					end
				end
				imh_pkg::REQ_POP: begin
					if (fill == 0)
						a.st = imh_pkg::ST_EMPTY;
					else begin
						lk = slot_key[fill];
						ln = slot_node[fill];
						a.popped = slot_node[1];
						where[slot_node[1]] = 0;
						fill--;
						if (fill > 0)
							sink(1, lk, ln);
					end
				end
				imh_pkg::REQ_UPDATE: begin
					p = where[n];
					if (p == 0)
						a.st = imh_pkg::ST_NOT_PRESENT;
					else if (slot_key[p] != k) begin
						if (p > 1 && k < slot_key[p / 2])
							lift(p, k, n);
						else
							sink(p, k, n);
					end
				end
				default: begin
					for (int unsigned i = 1; i <= fill; i++)
						where[slot_node[i]] = 0;
					fill = 0;
				end
			endcase
			a.cnt = fill[imh_pkg::CountWidth-1:0];
			pending.push_back(a);
		endfunction

		function bit check(node_t popped, logic [imh_pkg::StatusWidth-1:0] st,
				logic [imh_pkg::CountWidth-1:0] cnt, output string msg);
			answer_t a;
			if (pending.size() == 0) begin
				msg = "answer with no transaction outstanding";
				return 0;
			end
			a = pending.pop_front();
			if (popped !== a.popped || st !== a.st || cnt !== a.cnt) begin
				msg = $sformatf("popped %0d/%0d status %0d/%0d count %0d/%0d (got/exp)",
					popped, a.popped, st, a.st, cnt, a.cnt);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [imh_pkg::ReqWidth-1:0] req_type;
	node_t node_id;
	key_t key;
	logic done;
	node_t popped_node;
	logic [imh_pkg::StatusWidth-1:0] status;
	logic [imh_pkg::CountWidth-1:0] count;

	heap_scoreboard sb = new();
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	indexed_min_heap_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .node_id(node_id), .key(key),
		.done(done), .popped_node(popped_node), .status(status), .count(count)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n && done && !sb.check(popped_node, status, count, msg))
			report(msg);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else if (idle_cycles >= IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Each transaction is followed by a gap only when the current burst runs out.
	task automatic send(imh_pkg::req_t r, node_t n, key_t k);
		start <= 1'b1;
		req_type <= r;
		node_id <= n;
		key <= k;
		do @(posedge clk); while (busy);
		sb.note(r, n, k);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic key_t pick_key();
		case ($urandom_range(0, 3))
			0: return key_t'($urandom_range(0, 15)) - key_t'(8);
			1: return {1'b1, 31'($urandom)};
			default: return key_t'($urandom);
		endcase
	endfunction

	function automatic node_t pick_node();
		if ($urandom_range(0, 4) == 0)
			return node_t'($urandom);
		return node_t'($urandom_range(0, 63));
	endfunction

	initial begin
		int roll;
		arst_n = 0;
		start = 0;
		req_type = imh_pkg::REQ_INSERT;
		node_id = '0;
		key = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send(imh_pkg::REQ_POP, '0, '0);
		send(imh_pkg::REQ_INSERT, '0, 32'sh8000_0000);
		send(imh_pkg::REQ_INSERT, 12'hFFF, 32'sh7FFF_FFFF);
		send(imh_pkg::REQ_INSERT, '0, 32'sd5);
		send(imh_pkg::REQ_UPDATE, 12'd5, 32'sd1);
		send(imh_pkg::REQ_UPDATE, '0, 32'sh8000_0000);
		send(imh_pkg::REQ_UPDATE, 12'hFFF, -32'sd100);
		send(imh_pkg::REQ_UPDATE, 12'hFFF, 32'sh7FFF_FFFF);
		send(imh_pkg::REQ_INSERT, 12'd1, 32'sd7);
		send(imh_pkg::REQ_INSERT, 12'd2, 32'sd7);
		send(imh_pkg::REQ_INSERT, 12'd3, 32'sd7);
		send(imh_pkg::REQ_UPDATE, '0, 32'sd7);
		send(imh_pkg::REQ_POP, '0, '0);
		send(imh_pkg::REQ_POP, 12'hABC, -32'sd1);
		send(imh_pkg::REQ_POP, '0, '0);
		send(imh_pkg::REQ_CLEAR, 12'd7, 32'sd7);
		send(imh_pkg::REQ_POP, '0, '0);
		send(imh_pkg::REQ_UPDATE, 12'd1, 32'sd3);
		drain();

		// Fill to capacity, then push past it.
		for (int i = 0; i < Capacity + 6; i++)
			send(imh_pkg::REQ_INSERT, node_t'(i), pick_key());
		send(imh_pkg::REQ_INSERT, '0, '0);
		for (int i = 0; i < 40; i++)
			send(imh_pkg::REQ_UPDATE, node_t'($urandom_range(0, Capacity - 1)), pick_key());
		for (int i = 0; i < 40; i++)
			send(imh_pkg::REQ_POP, node_t'($urandom), key_t'($urandom));
		send(imh_pkg::REQ_CLEAR, '0, '0);

		for (int i = 0; i < 420; i++) begin
			roll = $urandom_range(0, 99);
			if (i == 200)
				drain();
			if (roll < 38)
				send(imh_pkg::REQ_INSERT, pick_node(), pick_key());
			else if (roll < 68)
				send(imh_pkg::REQ_POP, node_t'($urandom), key_t'($urandom));
			else if (roll < 99)
				send(imh_pkg::REQ_UPDATE, pick_node(), pick_key());
			else
				send(imh_pkg::REQ_CLEAR, node_t'($urandom), key_t'($urandom));
		end
		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
design/imh_pkg.sv
design/indexed_min_heap_top.sv
test/tb.sv
